FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is low.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, switched off while reset is low.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

// Next-cycle implication that also runs during reset.
`define ASSERT_ALWAYS_NEXT(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("reset behaviour check failed");

`endif

FILE: rtl/hmrd_pkg.sv
`timescale 1ns / 1ps

package hmrd_pkg;

    // Report buffer and stream word geometry.
    localparam int HMRD_REPORT_BYTES = 8;
    localparam int BUF_BYTES         = 8;
    localparam int DATA_W            = 64;
    localparam int LEN_W             = 4;
    localparam int IN_TDATA_W        = 72;
    localparam int OUT_TDATA_W       = 24;
    localparam int AXIS_W            = 8;

    // Configuration port geometry.
    localparam int CFG_AW            = 6;
    localparam int CFG_DW            = 64;
    localparam int LAYOUT_W          = 12;
    localparam int BTN_LAYOUT_W      = 33;
    localparam int BTN_FIELD_W       = 11;
    localparam int NUM_BUTTONS       = 3;

    // Register reset values.
    localparam logic [LAYOUT_W-1:0]     X_LAYOUT_RST = 12'd2568;
    localparam logic [LAYOUT_W-1:0]     Y_LAYOUT_RST = 12'd2576;
    localparam logic [BTN_LAYOUT_W-1:0] BTN_LAYOUT_RST = 33'd134250504;

    // Register index, taken from paddr above the 8-byte lane.
    typedef enum logic [2:0] {
        REG_ID_PRESENT = 3'd0,
        REG_IS_MOUSE   = 3'd1,
        REG_X_LAYOUT   = 3'd2,
        REG_Y_LAYOUT   = 3'd3,
        REG_BUTTONS    = 3'd4
    } t_reg_idx;

    // Configuration handed from the register file to the datapath.
    typedef struct packed {
        logic                    id_present;
        logic                    is_mouse;
        logic [LAYOUT_W-1:0]     x_layout;
        logic [LAYOUT_W-1:0]     y_layout;
        logic [BTN_LAYOUT_W-1:0] buttons;
    } t_cfg;

endpackage

FILE: rtl/hmrd_cfg.sv
`timescale 1ns / 1ps

module hmrd_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [hmrd_pkg::CFG_AW-1:0] paddr,
    input  logic [hmrd_pkg::CFG_DW-1:0] pwdata,
    output logic [hmrd_pkg::CFG_DW-1:0] prdata,
    output logic                        pready,
    output hmrd_pkg::t_cfg              o_cfg
);
    import hmrd_pkg::*;

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[CFG_AW-1:3]);
    assign w_wr   = psel & penable & pwrite & pready;

    // Write decode; addresses past the last register are ignored.
    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            case (w_idx)
                REG_ID_PRESENT: n_cfg.id_present = pwdata[0];
                REG_IS_MOUSE:   n_cfg.is_mouse   = pwdata[0];
                REG_X_LAYOUT:   n_cfg.x_layout   = pwdata[LAYOUT_W-1:0];
                REG_Y_LAYOUT:   n_cfg.y_layout   = pwdata[LAYOUT_W-1:0];
                REG_BUTTONS:    n_cfg.buttons    = pwdata[BTN_LAYOUT_W-1:0];
                default:        n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.id_present <= 1'b0;
            r_cfg.is_mouse   <= 1'b1;
            r_cfg.x_layout   <= X_LAYOUT_RST;
            r_cfg.y_layout   <= Y_LAYOUT_RST;
            r_cfg.buttons    <= BTN_LAYOUT_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Read-back multiplexer.
    always_comb begin
        case (w_idx)
            REG_ID_PRESENT: prdata = CFG_DW'(r_cfg.id_present);
            REG_IS_MOUSE:   prdata = CFG_DW'(r_cfg.is_mouse);
            REG_X_LAYOUT:   prdata = CFG_DW'(r_cfg.x_layout);
            REG_Y_LAYOUT:   prdata = CFG_DW'(r_cfg.y_layout);
            REG_BUTTONS:    prdata = CFG_DW'(r_cfg.buttons);
            default:        prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

FILE: rtl/hmrd_axis.sv
`timescale 1ns / 1ps

module hmrd_axis (
    input  logic [hmrd_pkg::DATA_W-1:0]   i_data,
    input  logic [hmrd_pkg::LAYOUT_W-1:0] i_layout,
    output logic [hmrd_pkg::AXIS_W-1:0]   o_value
);
    import hmrd_pkg::*;

    localparam logic signed [17:0] AXIS_MAX = 18'sd127;
    localparam logic signed [17:0] AXIS_MIN = -18'sd128;
    localparam logic [4:0]         SIZE_CAP = 5'd16;

    logic [DATA_W+15:0] w_ext;
    logic [5:0]         w_off;
    logic [4:0]         w_size_cfg;
    logic [4:0]         w_size;
    logic               w_is_signed;
    logic [15:0]        w_win;
    logic [16:0]        w_span;
    logic [15:0]        w_mask;
    logic [15:0]        w_raw;
    logic               w_neg;
    logic signed [17:0] w_val;

    assign w_off       = i_layout[5:0];
    assign w_size_cfg  = i_layout[10:6];
    assign w_is_signed = i_layout[11];
    assign w_size      = (w_size_cfg > SIZE_CAP) ? SIZE_CAP : w_size_cfg;

    // Bits addressed past the buffer come in as zero from the extension.
    assign w_ext  = {16'd0, i_data};
    assign w_win  = 16'(w_ext >> w_off);
    assign w_span = 17'd1 << w_size;
    assign w_mask = 16'(w_span - 17'd1);
    assign w_raw  = w_win & w_mask;

    // Sign extension of the field from its top bit.
    assign w_neg = w_is_signed && (w_size != 5'd0) && w_raw[4'(w_size - 5'd1)];
    assign w_val = $signed({2'b00, w_raw}) - (w_neg ? $signed({1'b0, w_span}) : 18'sd0);

    // Saturate to the signed byte range.
    always_comb begin
        if (w_val > AXIS_MAX) begin
            o_value = AXIS_MAX[AXIS_W-1:0];
        end else if (w_val < AXIS_MIN) begin
            o_value = AXIS_MIN[AXIS_W-1:0];
        end else begin
            o_value = w_val[AXIS_W-1:0];
        end
    end

endmodule

FILE: rtl/hid_mouse_report_decoder.sv
`timescale 1ns / 1ps

// HID mouse report decoder.
// Reports enter on the s_axis channel: one word carries up to eight report
// bytes and the byte count. Each accepted word gives exactly one word on the
// m_axis channel holding the held X and Y movement (clamped signed bytes) and
// the three held button states, with tuser flagging a zero-length report.
// The register bank on the APB port selects the report ID skip, whether the
// report type is a mouse, the two axis layouts and the button layout; the user
// must write it only while the block is idle, as the block does not enforce it.
// A word accepted into the input register passes through the extraction
// logic into the result register, from which it is shown on m_axis.
// Throughput is one word per cycle while the receiver does not stall, set by
// the single pass of extraction logic between those two registers.
// When the receiver stalls, the result word holds, the input register still
// takes one more word, and s_axis_tready then falls until the result is taken.
// Reset clears both valid flags, zeroes the held movement and buttons and
// returns the registers to their defaults.
module hid_mouse_report_decoder #(
    parameter int REPORT_BYTES = hmrd_pkg::HMRD_REPORT_BYTES
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // s_axis_tdata: report_bytes [63:0], report_length [67:64], zero pad
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [hmrd_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // m_axis_tdata: move_x [7:0], move_y [15:8], button_left [16],
    // button_right [17], button_middle [18], zero pad
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [hmrd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // m_axis_tuser: decode_failed [0]
    output logic                             m_axis_tuser,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [hmrd_pkg::CFG_AW-1:0]      paddr,
    input  logic [hmrd_pkg::CFG_DW-1:0]      pwdata,
    output logic [hmrd_pkg::CFG_DW-1:0]      prdata,
    output logic                             pready
);
    import hmrd_pkg::*;

    localparam int              STORE_W = REPORT_BYTES * 8;
    localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(REPORT_BYTES);

    t_cfg                    w_cfg;
    logic                    r_in_valid;
    logic [STORE_W-1:0]      r_in_data;
    logic [LEN_W-1:0]        r_in_len;
    logic                    r_out_valid;
    logic                    r_failed;
    logic [AXIS_W-1:0]       r_held_x;
    logic [AXIS_W-1:0]       r_held_y;
    logic [NUM_BUTTONS-1:0]  r_held_btn;
    logic                    w_out_ready;
    logic                    w_adv;
    logic                    w_in_acc;
    logic [LEN_W-1:0]        w_len_c;
    logic [DATA_W-1:0]       w_data;
    logic [DATA_W-1:0]       w_shift;
    logic [AXIS_W-1:0]       w_x;
    logic [AXIS_W-1:0]       w_y;
    logic [NUM_BUTTONS-1:0]  w_btn;

    hmrd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Pipeline flow control: the result register frees the input register.
    assign w_out_ready   = !r_out_valid || m_axis_tready;
    assign w_adv         = r_in_valid && w_out_ready;
    assign s_axis_tready = !r_in_valid || w_adv;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
        if (w_in_acc) begin
            r_in_data <= s_axis_tdata[STORE_W-1:0];
            r_in_len  <= s_axis_tdata[DATA_W +: LEN_W];
        end
    end

    // Bytes past the report length or past the buffer read as zero.
    assign w_len_c = (r_in_len > LEN_CAP) ? LEN_CAP : r_in_len;

    for (genvar gi = 0; gi < BUF_BYTES; gi++) begin : g_byte
        if (gi < REPORT_BYTES) begin : g_live
            assign w_data[8*gi +: 8] = (LEN_W'(gi) < w_len_c) ? r_in_data[8*gi +: 8] : 8'd0;
        end else begin : g_absent
            assign w_data[8*gi +: 8] = 8'd0;
        end
    end

    // Skip the report ID byte when one is present.
    assign w_shift = w_cfg.id_present ? {8'd0, w_data[DATA_W-1:8]} : w_data;

    hmrd_axis u_axis_x (
        .i_data   (w_shift),
        .i_layout (w_cfg.x_layout),
        .o_value  (w_x)
    );

    hmrd_axis u_axis_y (
        .i_data   (w_shift),
        .i_layout (w_cfg.y_layout),
        .o_value  (w_y)
    );

    // Each button tests one byte against its mask.
    always_comb begin
        logic [BTN_FIELD_W-1:0] fld;
        logic [7:0]             sel_byte;
        for (int b = 0; b < NUM_BUTTONS; b++) begin
            fld      = w_cfg.buttons[BTN_FIELD_W*b +: BTN_FIELD_W];
            sel_byte = w_shift[{fld[2:0], 3'b000} +: 8];
            w_btn[b] = |(sel_byte & fld[10:3]);
        end
    end

    // Result register and held state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_held_x    <= '0;
            r_held_y    <= '0;
            r_held_btn  <= '0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
            if ((r_in_len != '0) && w_cfg.is_mouse) begin
                r_held_x   <= w_x;
                r_held_y   <= w_y;
                r_held_btn <= w_btn;
            end
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (w_adv) begin
            r_failed <= (r_in_len == '0);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_failed;
    assign m_axis_tdata  = {5'd0, r_held_btn, r_held_y, r_held_x};

endmodule

FILE: rtl/hmrd_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hmrd_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [hmrd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                             m_axis_tuser
);
    import hmrd_pkg::*;

    // A stalled result word holds its contents.
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // With the result register empty the block always takes a word.
    `ASSERT_IMPLIES(a_ready_when_empty, i_clk, i_rst_n, !m_axis_tvalid, s_axis_tready)

    // After an accepted word the block has a result word on show.
    `ASSERT_IMPLIES(a_latency, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, ##2 m_axis_tvalid)

    // Reset leaves the output empty and the input open.
    `ASSERT_ALWAYS_NEXT(a_reset, i_clk, !i_rst_n, !m_axis_tvalid && s_axis_tready)

endmodule

bind hid_mouse_report_decoder hmrd_checker u_hmrd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

FILE: verif/hid_mouse_report_decoder_checker.sv
`timescale 1ns / 1ps

// Watches the report stream, the result stream and the register port of the
// mouse report decoder. Every report word that is accepted is decoded here
// into the held movement and buttons it should leave behind, and every result
// word that is taken is compared with the oldest of those decodes.
module hid_mouse_report_decoder_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    input  logic                              i_s_axis_tready,
    // i_s_axis_tdata: report_bytes [63:0], report_length [67:64], zero pad
    input  logic [hmrd_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,
    input  logic                              i_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // i_m_axis_tdata: move_x [7:0], move_y [15:8], button_left [16],
    // button_right [17], button_middle [18], zero pad
    input  logic [hmrd_pkg::OUT_TDATA_W-1:0]  i_m_axis_tdata,
    // i_m_axis_tuser: decode_failed [0]
    input  logic                              i_m_axis_tuser,
    input  logic                              i_psel,
    input  logic                              i_penable,
    input  logic                              i_pwrite,
    input  logic                              i_pready,
    input  logic [hmrd_pkg::CFG_AW-1:0]       i_paddr,
    input  logic [hmrd_pkg::CFG_DW-1:0]       i_pwdata,
    output int                                o_fail_count,
    output int                                o_pending
);
    import hmrd_pkg::*;

    typedef struct packed {
        logic                   failed;
        logic [AXIS_W-1:0]      x;
        logic [AXIS_W-1:0]      y;
        logic [NUM_BUTTONS-1:0] buttons;
    } t_mouse_state;

    t_mouse_state           expected_moves[$];
    t_cfg                   cfg;
    logic [AXIS_W-1:0]      held_x;
    logic [AXIS_W-1:0]      held_y;
    logic [NUM_BUTTONS-1:0] held_buttons;
    int                     mismatches = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // Pulls one axis field out of the report, LSB first, then clamps it to a
    // signed byte. Bits that fall outside the buffer read as zero.
    function automatic logic [AXIS_W-1:0] extract_axis(input logic [DATA_W-1:0] bytes_in,
                                                       input logic base,
                                                       input logic [LAYOUT_W-1:0] layout);
        int          size;
        int          pos;
        int          idx;
        int          k;
        int          val;
        logic [15:0] raw;
        size = int'(layout[10:6]);
        if (size > 16) begin
            size = 16;
        end
        raw = '0;
        for (k = 0; k < size; k++) begin
            pos = int'(layout[5:0]) + k;
            idx = int'(base) + pos / 8;
            if (idx < HMRD_REPORT_BYTES) begin
                raw[k] = bytes_in[8 * idx + pos % 8];
            end
        end
        val = int'(raw);
        if (layout[11] && size > 0) begin
            if (raw[size - 1]) begin
                val -= 1 << size;
            end
        end
        if (val > 127) begin
            val = 127;
        end
        if (val < -128) begin
            val = -128;
        end
        return val[AXIS_W-1:0];
    endfunction

    // Decodes one report against the current registers and updates the held
    // state when the report type is a mouse.
    function automatic t_mouse_state predict_report(input logic [DATA_W-1:0] bytes_in,
                                                    input logic [LEN_W-1:0] len);
        t_mouse_state           res;
        logic [DATA_W-1:0]      valid_bytes;
        logic [AXIS_W-1:0]      nx;
        logic [AXIS_W-1:0]      ny;
        logic [NUM_BUTTONS-1:0] nb;
        logic [BTN_FIELD_W-1:0] fld;
        int                     used;
        int                     idx;
        int                     b;
        res.failed = (len == 0);
        if (len != 0) begin
            used = (int'(len) > HMRD_REPORT_BYTES) ? HMRD_REPORT_BYTES : int'(len);
            valid_bytes = bytes_in;
            for (idx = used; idx < BUF_BYTES; idx++) begin
                valid_bytes[8 * idx +: 8] = 8'h00;
            end
            nx = extract_axis(valid_bytes, cfg.id_present, cfg.x_layout);
            ny = extract_axis(valid_bytes, cfg.id_present, cfg.y_layout);
            nb = '0;
            for (b = 0; b < NUM_BUTTONS; b++) begin
                fld = cfg.buttons[BTN_FIELD_W * b +: BTN_FIELD_W];
                idx = int'(cfg.id_present) + int'(fld[2:0]);
                if (idx < HMRD_REPORT_BYTES) begin
                    nb[b] = |(valid_bytes[8 * idx +: 8] & fld[10:3]);
                end
            end
            if (cfg.is_mouse) begin
                held_x       = nx;
                held_y       = ny;
                held_buttons = nb;
            end
        end
        res.x       = held_x;
        res.y       = held_y;
        res.buttons = held_buttons;
        return res;
    endfunction

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Register writes, result comparison and report decoding, all at the edge
    // where the handshake completes.
    always @(posedge i_clk) begin
        t_mouse_state want;
        if (!i_rst_n) begin
            cfg.id_present = 1'b0;
            cfg.is_mouse   = 1'b1;
            cfg.x_layout   = X_LAYOUT_RST;
            cfg.y_layout   = Y_LAYOUT_RST;
            cfg.buttons    = BTN_LAYOUT_RST;
            held_x         = '0;
            held_y         = '0;
            held_buttons   = '0;
            expected_moves.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg_idx'(i_paddr[CFG_AW-1:3]))
                    REG_ID_PRESENT: cfg.id_present = i_pwdata[0];
                    REG_IS_MOUSE:   cfg.is_mouse   = i_pwdata[0];
                    REG_X_LAYOUT:   cfg.x_layout   = i_pwdata[LAYOUT_W-1:0];
                    REG_Y_LAYOUT:   cfg.y_layout   = i_pwdata[LAYOUT_W-1:0];
                    REG_BUTTONS:    cfg.buttons    = i_pwdata[BTN_LAYOUT_W-1:0];
                    default: ;
                endcase
            end
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (expected_moves.size() == 0) begin
                    $display("%0t: result word with none expected, expected nothing, actual %0h/%0h",
                             $time, i_m_axis_tuser, i_m_axis_tdata);
                    mismatches++;
                end else begin
                    want = expected_moves.pop_front();
                    compare_field("decode_failed", want.failed, i_m_axis_tuser);
                    compare_field("move_x", want.x, i_m_axis_tdata[7:0]);
                    compare_field("move_y", want.y, i_m_axis_tdata[15:8]);
                    compare_field("buttons", want.buttons, i_m_axis_tdata[18:16]);
                end
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                expected_moves.push_back(predict_report(i_s_axis_tdata[DATA_W-1:0],
                                                        i_s_axis_tdata[DATA_W +: LEN_W]));
            end
        end
        o_pending    <= expected_moves.size();
        o_fail_count <= mismatches;
    end

endmodule

FILE: verif/hid_mouse_report_decoder_tb.sv
`timescale 1ns / 1ps

// Drives reports into the decoder in bursts, stalls the result side on its
// own pattern, and steps the registers through a series of layouts between
// phases. The checker beside the block does all the predicting.
module hid_mouse_report_decoder_tb;
    import hmrd_pkg::*;

    typedef enum int {
        READY_ALWAYS,
        READY_COIN,
        READY_MOSTLY,
        READY_STALL
    } t_ready_mode;

    logic                   i_clk          = 1'b0;
    logic                   i_rst_n        = 1'b0;
    logic                   s_axis_tvalid  = 1'b0;
    logic [IN_TDATA_W-1:0]  s_axis_tdata   = '0;
    logic                   m_axis_tready  = 1'b0;
    logic                   psel           = 1'b0;
    logic                   penable        = 1'b0;
    logic                   pwrite         = 1'b0;
    logic [CFG_AW-1:0]      paddr          = '0;
    logic [CFG_DW-1:0]      pwdata         = '0;
    wire                    s_axis_tready;
    wire                    m_axis_tvalid;
    wire [OUT_TDATA_W-1:0]  m_axis_tdata;
    wire                    m_axis_tuser;
    wire [CFG_DW-1:0]       prdata;
    wire                    pready;
    int                     fail_count;
    int                     pending;
    int                     burst_left = 0;

    hid_mouse_report_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    hid_mouse_report_decoder_checker checker_i (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_axis_tvalid),
        .i_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .i_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .i_m_axis_tdata  (m_axis_tdata),
        .i_m_axis_tuser  (m_axis_tuser),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_pready        (pready),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    always #5 i_clk = ~i_clk;

    // Hard stop in case the block hangs.
    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    // Result side: runs of always ready, coin toss, mostly ready or full stall.
    initial begin
        t_ready_mode mode;
        int          run;
        forever begin
            mode = t_ready_mode'($urandom_range(0, 3));
            run  = (mode == READY_STALL) ? $urandom_range(1, 12) : $urandom_range(4, 40);
            repeat (run) begin
                @(posedge i_clk);
                case (mode)
                    READY_ALWAYS: m_axis_tready <= 1'b1;
                    READY_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
                    READY_MOSTLY: m_axis_tready <= ($urandom_range(0, 7) != 0);
                    default:      m_axis_tready <= 1'b0;
                endcase
            end
        end
    end

    // One register write: setup cycle, then access cycle.
    task automatic write_reg(input t_reg_idx idx, input logic [CFG_DW-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apply_config(input logic id, input logic mouse,
                                input logic [LAYOUT_W-1:0] x_layout,
                                input logic [LAYOUT_W-1:0] y_layout,
                                input logic [BTN_LAYOUT_W-1:0] buttons);
        write_reg(REG_ID_PRESENT, CFG_DW'(id));
        write_reg(REG_IS_MOUSE, CFG_DW'(mouse));
        write_reg(REG_X_LAYOUT, CFG_DW'(x_layout));
        write_reg(REG_Y_LAYOUT, CFG_DW'(y_layout));
        write_reg(REG_BUTTONS, CFG_DW'(buttons));
    endtask

    // Packs the three button fields, left in the lowest bits.
    function automatic logic [BTN_LAYOUT_W-1:0] btn_layout(input logic [2:0] l_off,
                                                          input logic [7:0] l_mask,
                                                          input logic [2:0] r_off,
                                                          input logic [7:0] r_mask,
                                                          input logic [2:0] m_off,
                                                          input logic [7:0] m_mask);
        return {m_mask, m_off, r_mask, r_off, l_mask, l_off};
    endfunction

    function automatic logic [LAYOUT_W-1:0] random_layout();
        if ($urandom_range(0, 5) == 0) begin
            return LAYOUT_W'($urandom);
        end
        return {1'($urandom_range(0, 1)), 5'($urandom_range(1, 16)), 6'($urandom_range(0, 48))};
    endfunction

    function automatic logic [BTN_LAYOUT_W-1:0] random_buttons();
        logic [BTN_LAYOUT_W-1:0] res;
        int                      b;
        if ($urandom_range(0, 4) == 0) begin
            return {1'($urandom_range(0, 1)), 32'($urandom)};
        end
        res = '0;
        for (b = 0; b < NUM_BUTTONS; b++) begin
            res[BTN_FIELD_W * b +: 3] = 3'($urandom_range(0, 6));
            res[BTN_FIELD_W * b + 3 +: 8] = ($urandom_range(0, 1) != 0) ?
                8'(1 << $urandom_range(0, 7)) : 8'($urandom);
        end
        return res;
    endfunction

    // Sends one report word. Bursts of back-to-back words are broken by
    // random gaps with tvalid low.
    task automatic send_report(input logic [DATA_W-1:0] data, input logic [LEN_W-1:0] len);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_TDATA_W - DATA_W - LEN_W){1'b0}}, len, data};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Mostly valid lengths, with zero and oversize lengths mixed in.
    task automatic send_random();
        int               pick;
        logic [LEN_W-1:0] len;
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
            len = '0;
        end else if (pick == 1) begin
            len = LEN_W'($urandom_range(9, 15));
        end else begin
            len = LEN_W'($urandom_range(1, 8));
        end
        send_report({32'($urandom), 32'($urandom)}, len);
    endtask

    // Stops sending and waits until every expected word has been taken.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    initial begin
        int p;
        int k;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset layout: zero length, empty and full reports, oversize length.
        send_report('1, 4'd0);
        send_report('0, 4'd8);
        send_report('1, 4'd8);
        send_report('1, 4'd1);
        send_report('1, 4'd15);
        send_report(64'h55AA_55AA_55AA_55AA, 4'd3);
        drain();

        // Report ID skipped, unsigned 16-bit X and signed 16-bit Y.
        apply_config(1'b1, 1'b1, {1'b0, 5'd16, 6'd0}, {1'b1, 5'd16, 6'd16},
                     btn_layout(3'd0, 8'h01, 3'd1, 8'h80, 3'd6, 8'hFF));
        send_report({24'h0, 16'h8000, 16'h7FFF, 8'h01}, 4'd5);
        send_report({24'h0, 16'hFFFF, 16'h0001, 8'h02}, 4'd5);
        send_report({24'h0, 16'h0040, 16'hFFFF, 8'h03}, 4'd5);
        send_report({24'hFFFFFF, 16'hFFFF, 16'hFFFF, 8'h01}, 4'd3);
        drain();

        // Zero-size X, oversize Y running off the end of the buffer.
        apply_config(1'b0, 1'b1, {1'b1, 5'd0, 6'd5}, {1'b1, 5'd31, 6'd60},
                     btn_layout(3'd7, 8'hFF, 3'd7, 8'h01, 3'd0, 8'h80));
        send_report('1, 4'd8);
        send_report(64'h8000_0000_0000_0080, 4'd8);
        send_report('1, 4'd7);
        drain();

        // Non-mouse report type: held values must not move.
        apply_config(1'b0, 1'b0, {1'b1, 5'd8, 6'd8}, {1'b1, 5'd8, 6'd16},
                     btn_layout(3'd0, 8'h01, 3'd0, 8'h02, 3'd0, 8'h04));
        send_report('1, 4'd8);
        send_report('0, 4'd0);
        send_report(64'h0000_0000_0012_3407, 4'd3);
        drain();

        // Every register at its top value, then every register at zero.
        apply_config(1'b1, 1'b1, '1, '1, '1);
        send_report('1, 4'd8);
        send_report(64'h7F00_0000_0000_0000, 4'd8);
        drain();
        apply_config(1'b0, 1'b0, '0, '0, '0);
        send_report('1, 4'd8);
        drain();

        // Random phases, each under a fresh register setting.
        for (p = 0; p < 12; p++) begin
            apply_config(1'($urandom_range(0, 1)), ($urandom_range(0, 4) != 0),
                         random_layout(), random_layout(), random_buttons());
            for (k = 0; k < 108; k++) begin
                if (p == 3 && k == 54) begin
                    drain();
                end
                send_random();
            end
            drain();
        end

        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
